// ----- design/ipv4_address_blacklist_filter_unit_defines.svh -----
// Assertion macros shared by the filter design files.
// They assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef IPV4_ADDRESS_BLACKLIST_FILTER_UNIT_DEFINES_SVH
`define IPV4_ADDRESS_BLACKLIST_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IBF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ipv4 filter assertion failed");
`define IBF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipv4 filter assertion failed");
`define IBF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipv4 filter assertion failed");
`else
`define IBF_ASSERT(lbl, prop)
`define IBF_ASSERT_IMPL(lbl, ante, cons)
`define IBF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/ipv4bf_pkg.sv -----
`default_nettype none

package ipv4bf_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam logic [1:0] CMD_FILTER = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_PRESENT   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic       drop;
		logic [1:0] status;
	} rsp_t;

	// Command token as it walks the chain, with what the slots so far reported.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
		logic        hit;
		logic        free_seen;
	} token_t;

	typedef struct packed {
		logic finish;
		logic commit;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/ipv4bf_cell.sv -----
`default_nettype none

module ipv4bf_cell
	import ipv4bf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      prev_vld,
	input  wire token_t    prev_tok,
	input  wire cell_ctl_t ctl,
	output logic           next_vld,
	output token_t         next_tok
);

	logic        valid_q;
	logic        pending_q;
	logic        vld_q;
	logic [31:0] addr_q;
	token_t      tok_q;
	logic        match;
	logic        free;
	logic        claim;
	token_t      tok_upd;

	assign match = valid_q && (addr_q == prev_tok.address);
	assign free  = !valid_q && !pending_q;
	// The lowest free slot reserves itself for an add; the end of the chain
	// confirms the reservation only if no slot held the address.
	assign claim = prev_vld && (prev_tok.cmd == CMD_ADD) && free && !prev_tok.free_seen;

	always_comb begin
		tok_upd           = prev_tok;
		tok_upd.hit       = prev_tok.hit | match;
		tok_upd.free_seen = prev_tok.free_seen | free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pending_q <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			vld_q <= prev_vld;
			if (ctl.finish) begin
				pending_q <= 1'b0;
				if (ctl.commit && pending_q) begin
					valid_q <= 1'b1;
				end
			end else if (claim) begin
				pending_q <= 1'b1;
			end else if (prev_vld && (prev_tok.cmd == CMD_REMOVE) && match) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			addr_q <= prev_tok.address;
		end
		if (prev_vld) begin
			tok_q <= tok_upd;
		end
	end

	assign next_vld = vld_q;
	assign next_tok = tok_q;

endmodule

`default_nettype wire

// ----- design/ipv4_address_blacklist_filter_unit.sv -----
// Exact-match IPv4 address table, one command per transaction.
// The req channel carries a command (filter, add, remove) and an address; the
// rsp channel returns one result per command with drop and status fields.
// A command travels as a token through a chain of ENTRIES slot cells, one
// cell per cycle; each cell compares its stored address, removes on a match,
// or reserves itself as the lowest free slot for an add. At the end of the
// chain the result is formed and a pending add is committed to its slot.
// The token is registered in every cell, and the result again in the output register.
// One command at a time: a new request is accepted only after the previous
// token has walked through the whole cell chain.
// Reset empties the table and the response registers; it takes effect at once.
// When the receiver stalls, the waiting result stays in the output register
// and the next command is still accepted; its result waits in a second
// register, and req_ready stays low until that register drains.
`default_nettype none
`include "ipv4_address_blacklist_filter_unit_defines.svh"

module ipv4_address_blacklist_filter_unit
	import ipv4bf_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic             busy_q;
	logic             rsp_valid_q;
	logic             skid_valid_q;
	rsp_t             rsp_q;
	rsp_t             skid_q;
	logic             accept;
	logic             finish;
	logic             rsp_take;
	rsp_t             result;
	cell_ctl_t        ctl;
	logic   [ENTRIES:0] vld;
	token_t           tok [ENTRIES+1];

	assign req_ready = !busy_q && !skid_valid_q;
	assign accept    = req_valid && req_ready;
	assign rsp_take  = rsp_valid_q && rsp_ready;

	assign tok[0] = {req.cmd, req.address, 1'b0, 1'b0};
	assign vld[0] = accept;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ipv4bf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_vld (vld[i]),
			.prev_tok (tok[i]),
			.ctl      (ctl),
			.next_vld (vld[i+1]),
			.next_tok (tok[i+1])
		);
	end

	assign finish = vld[ENTRIES];

	always_comb begin
		result.drop   = 1'b0;
		result.status = ST_DONE;
		ctl.finish    = finish;
		ctl.commit    = 1'b0;
		case (tok[ENTRIES].cmd)
			CMD_FILTER: begin
				result.drop = tok[ENTRIES].hit;
			end
			CMD_ADD: begin
				if (tok[ENTRIES].hit) begin
					result.status = ST_PRESENT;
				end else if (!tok[ENTRIES].free_seen) begin
					result.status = ST_FULL;
				end else begin
					ctl.commit = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!tok[ENTRIES].hit) begin
					result.status = ST_NOT_FOUND;
				end
			end
			default: begin
				result.status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (rsp_take) begin
				rsp_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (!rsp_valid_q || rsp_ready) begin
				rsp_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (rsp_take && skid_valid_q) begin
			rsp_q <= skid_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`IBF_ASSERT(a_one_token, $onehot0(vld))
	`IBF_ASSERT_IMPL(a_skid_behind_rsp, skid_valid_q, rsp_valid_q)
	`IBF_ASSERT_IMPL(a_finish_busy, finish, busy_q && !accept)
	`IBF_ASSERT_IMPL(a_finish_room, finish, !skid_valid_q)
	`IBF_ASSERT_NEXT(a_accept_busy, accept, busy_q && !req_ready)

endmodule

`default_nettype wire
